// ===== hdl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg: shared constants for the Legendre polynomial series generator
// Fixed-point formats, field widths, the sequencer state codes and the
// reciprocal table that turns the division by the degree into a product.
// ----------------------------------------------------------------------------
package lps_pkg;

	// Field widths.
	localparam int DATA_W    = 32;
	localparam int DEG_W     = 6;
	localparam int CNT_W     = 7;
	localparam int FRAC_BITS = 30;
	localparam int MAG_W     = 31;
	localparam int MAX_DEGREES = 64;

	// Datapath widths: recurrence numerator, its magnitude, reciprocal, accumulator.
	localparam int T_W     = 40;
	localparam int NUM_W   = 39;
	localparam int RECIP_W = 45;
	localparam int ACC_W   = 84;

	// Split points of the numerator and reciprocal for the partial products.
	localparam int NUM_LO_W   = 20;
	localparam int RECIP_LO_W = 23;

	// Reset value of the degree count register.
	localparam logic [CNT_W-1:0] DEGREE_COUNT_RESET = 7'd8;

	// Fixed-point one, its signed form and the rounding half.
	localparam logic [MAG_W-1:0]         ONE_MAG   = 31'h4000_0000;
	localparam logic signed [DATA_W-1:0] ONE_S     = 32'sh4000_0000;
	localparam logic signed [DATA_W-1:0] MINUS_ONE = -32'sh4000_0000;
	localparam logic [61:0]              ROUND_HALF = 62'h2000_0000;

	// Sequencer states, one-hot.
	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_MXP  = 13'b0000000000010,
		S_RND  = 13'b0000000000100,
		S_MU   = 13'b0000000001000,
		S_MP2  = 13'b0000000010000,
		S_T    = 13'b0000000100000,
		S_D0   = 13'b0000001000000,
		S_D1   = 13'b0000010000000,
		S_D2   = 13'b0000100000000,
		S_D3   = 13'b0001000000000,
		S_D4   = 13'b0010000000000,
		S_FIN  = 13'b0100000000000,
		S_EMIT = 13'b1000000000000
	} lps_state_t;

	// Reciprocals ceil(2^45 / l); degrees zero and one never divide.
	localparam longint unsigned RSC = 64'h0000_2000_0000_0000;
	localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_DEGREES] = '{
		45'd0,                   45'd0,                   45'((RSC + 1) / 2),
		45'((RSC + 2) / 3),      45'((RSC + 3) / 4),      45'((RSC + 4) / 5),
		45'((RSC + 5) / 6),      45'((RSC + 6) / 7),      45'((RSC + 7) / 8),
		45'((RSC + 8) / 9),      45'((RSC + 9) / 10),     45'((RSC + 10) / 11),
		45'((RSC + 11) / 12),    45'((RSC + 12) / 13),    45'((RSC + 13) / 14),
		45'((RSC + 14) / 15),    45'((RSC + 15) / 16),    45'((RSC + 16) / 17),
		45'((RSC + 17) / 18),    45'((RSC + 18) / 19),    45'((RSC + 19) / 20),
		45'((RSC + 20) / 21),    45'((RSC + 21) / 22),    45'((RSC + 22) / 23),
		45'((RSC + 23) / 24),    45'((RSC + 24) / 25),    45'((RSC + 25) / 26),
		45'((RSC + 26) / 27),    45'((RSC + 27) / 28),    45'((RSC + 28) / 29),
		45'((RSC + 29) / 30),    45'((RSC + 30) / 31),    45'((RSC + 31) / 32),
		45'((RSC + 32) / 33),    45'((RSC + 33) / 34),    45'((RSC + 34) / 35),
		45'((RSC + 35) / 36),    45'((RSC + 36) / 37),    45'((RSC + 37) / 38),
		45'((RSC + 38) / 39),    45'((RSC + 39) / 40),    45'((RSC + 40) / 41),
		45'((RSC + 41) / 42),    45'((RSC + 42) / 43),    45'((RSC + 43) / 44),
		45'((RSC + 44) / 45),    45'((RSC + 45) / 46),    45'((RSC + 46) / 47),
		45'((RSC + 47) / 48),    45'((RSC + 48) / 49),    45'((RSC + 49) / 50),
		45'((RSC + 50) / 51),    45'((RSC + 51) / 52),    45'((RSC + 52) / 53),
		45'((RSC + 53) / 54),    45'((RSC + 54) / 55),    45'((RSC + 55) / 56),
		45'((RSC + 56) / 57),    45'((RSC + 57) / 58),    45'((RSC + 58) / 59),
		45'((RSC + 59) / 60),    45'((RSC + 60) / 61),    45'((RSC + 61) / 62),
		45'((RSC + 62) / 63)
	};

	// Magnitude of a value known to lie in [-1, 1].
	function automatic logic [MAG_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] n;
		n = -v;
		return v[DATA_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

endpackage

// ===== hdl/legendre_polynomial_series.sv =====
// ----------------------------------------------------------------------------
// legendre_polynomial_series: Legendre polynomial values per abscissa
// Takes x in Q2.30, saturates it to [-1, 1] and emits P_0(x) .. P_{L-1}(x)
// through the three-term recurrence, evaluated on one shared multiplier.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (lowest bits first)
//  s_axis   in         tdata: abscissa[31:0]
//  m_axis   out        tdata: degree_index[5:0], poly_value[37:6], zero[39:38];
//                      tlast: last_of_run
//  cfg      in         wdata: degree_count[6:0]
//
// The run for an abscissa waits whenever the output side stalls. Each degree
// from two up runs twelve steps and uses the one 32 x 32 multiplier for
// x * P_{l-1}, the two recurrence terms and four partial products against
// the reciprocal of l.
// s_axis_tready is high only while the sequencer is idle; a result already in
// the output register may still wait while the next abscissa is taken.
// Reset clears the sequencer and output valid and sets L to 8.

module legendre_polynomial_series (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: degree_count[6:0]
	input  logic        cfg_wen,
	input  logic [lps_pkg::CNT_W-1:0] cfg_wdata,
	// Input items: abscissa[31:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	// Result items: degree_index[5:0], poly_value[37:6], zero fill[39:38]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,
	// last_of_run
	output logic        m_axis_tlast
);
	import lps_pkg::*;

	lps_state_t state_q;

	logic [CNT_W-1:0]         degree_count_q;
	logic [DEG_W-1:0]         l_q;
	logic [DEG_W-1:0]         last_l_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] p1_q;
	logic signed [DATA_W-1:0] p2_q;
	logic signed [DATA_W-1:0] cur_q;
	logic [MAG_W-1:0]         u_mag_q;
	logic                     u_neg_q;
	logic signed [T_W-1:0]    a_q;
	logic                     t_neg_q;
	logic [NUM_W-1:0]         n_q;
	logic [RECIP_W-1:0]       recip_q;
	logic [63:0]              prod_q;
	logic [ACC_W-1:0]         acc_q;

	logic                     out_valid_q;
	logic [DEG_W-1:0]         out_deg_q;
	logic signed [DATA_W-1:0] out_val_q;
	logic                     out_last_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	logic                     in_fire;
	logic                     out_free;
	logic signed [DATA_W-1:0] x_sat;
	logic [DEG_W-1:0]         last_l_in;
	logic [61:0]              rnd_sum;
	logic [31:0]              rnd_r;
	logic [MAG_W-1:0]         u_mag;
	logic [CNT_W-1:0]         coef_odd;
	logic signed [T_W-1:0]    prod_s;
	logic signed [T_W-1:0]    b_s;
	logic signed [T_W-1:0]    t_val;
	logic [T_W-1:0]           t_mag;
	logic [NUM_W-1:0]         q_raw;
	logic [MAG_W-1:0]         q_clamp;
	logic signed [DATA_W-1:0] q_pos;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_val_q, out_deg_q};
	assign m_axis_tlast  = out_last_q;

	// Saturate the abscissa and find the last degree of the run.
	always_comb begin
		if ($signed(s_axis_tdata) > ONE_S) begin
			x_sat = ONE_S;
		end else if ($signed(s_axis_tdata) < MINUS_ONE) begin
			x_sat = MINUS_ONE;
		end else begin
			x_sat = $signed(s_axis_tdata);
		end
		if (degree_count_q == '0) begin
			last_l_in = '0;
		end else if (degree_count_q >= CNT_W'(MAX_DEGREES)) begin
			last_l_in = DEG_W'(MAX_DEGREES - 1);
		end else begin
			last_l_in = DEG_W'(degree_count_q - 1'b1);
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		coef_odd = {l_q, 1'b0} - 1'b1;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MXP: begin
				mul_a = {1'b0, mag_of(x_q)};
				mul_b = {1'b0, mag_of(p1_q)};
			end
			S_MU: begin
				mul_a = 32'(coef_odd);
				mul_b = {1'b0, u_mag_q};
			end
			S_MP2: begin
				mul_a = 32'(l_q - 1'b1);
				mul_b = {1'b0, mag_of(p2_q)};
			end
			S_D0: begin
				mul_a = 32'(n_q[NUM_LO_W-1:0]);
				mul_b = 32'(recip_q[RECIP_LO_W-1:0]);
			end
			S_D1: begin
				mul_a = 32'(n_q[NUM_W-1:NUM_LO_W]);
				mul_b = 32'(recip_q[RECIP_LO_W-1:0]);
			end
			S_D2: begin
				mul_a = 32'(n_q[NUM_LO_W-1:0]);
				mul_b = 32'(recip_q[RECIP_W-1:RECIP_LO_W]);
			end
			S_D3: begin
				mul_a = 32'(n_q[NUM_W-1:NUM_LO_W]);
				mul_b = 32'(recip_q[RECIP_W-1:RECIP_LO_W]);
			end
			S_IDLE, S_RND, S_T, S_D4, S_FIN, S_EMIT: begin
				mul_a = '0;
				mul_b = '0;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	// Rounding of x * P_{l-1}, the recurrence numerator and the final clamp.
	always_comb begin
		rnd_sum = prod_q[61:0] + ROUND_HALF;
		rnd_r   = rnd_sum[61:FRAC_BITS];
		u_mag   = (rnd_r > 32'(ONE_MAG)) ? ONE_MAG : rnd_r[MAG_W-1:0];
		prod_s  = $signed(prod_q[T_W-1:0]);
		b_s     = p2_q[DATA_W-1] ? -prod_s : prod_s;
		t_val   = a_q - b_s;
		t_mag   = t_val[T_W-1] ? T_W'(-t_val) : T_W'(t_val);
		q_raw   = acc_q[ACC_W-1:RECIP_W];
		q_clamp = (q_raw > NUM_W'(ONE_MAG)) ? ONE_MAG : q_raw[MAG_W-1:0];
		q_pos   = $signed({1'b0, q_clamp});
	end

	// Configuration register, sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			degree_count_q <= DEGREE_COUNT_RESET;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				degree_count_q <= cfg_wdata;
			end
			// A new result fills the output register; a taken one empties it.
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EMIT;
					end
				end
				S_MXP: state_q <= S_RND;
				S_RND: state_q <= S_MU;
				S_MU:  state_q <= S_MP2;
				S_MP2: state_q <= S_T;
				S_T:   state_q <= S_D0;
				S_D0:  state_q <= S_D1;
				S_D1:  state_q <= S_D2;
				S_D2:  state_q <= S_D3;
				S_D3:  state_q <= S_D4;
				S_D4:  state_q <= S_FIN;
				S_FIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						if (l_q == last_l_q) begin
							state_q <= S_IDLE;
						end else if (l_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_MXP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					x_q      <= x_sat;
					last_l_q <= last_l_in;
					l_q      <= '0;
					cur_q    <= ONE_S;
				end
			end
			S_RND: begin
				u_mag_q <= u_mag;
				u_neg_q <= x_q[DATA_W-1] ^ p1_q[DATA_W-1];
			end
			S_MP2: begin
				a_q <= u_neg_q ? -$signed(prod_q[T_W-1:0]) : $signed(prod_q[T_W-1:0]);
			end
			S_T: begin
				t_neg_q <= t_val[T_W-1];
				n_q     <= t_mag[NUM_W-1:0] + NUM_W'(l_q >> 1);
				recip_q <= RECIP_TABLE[l_q];
			end
			S_D1: acc_q <= ACC_W'(prod_q);
			S_D2: acc_q <= acc_q + (ACC_W'(prod_q) << NUM_LO_W);
			S_D3: acc_q <= acc_q + (ACC_W'(prod_q) << RECIP_LO_W);
			S_D4: acc_q <= acc_q + (ACC_W'(prod_q) << (NUM_LO_W + RECIP_LO_W));
			S_FIN: begin
				cur_q <= t_neg_q ? -q_pos : q_pos;
			end
			S_EMIT: begin
				if (out_free) begin
					out_deg_q  <= l_q;
					out_val_q  <= cur_q;
					out_last_q <= (l_q == last_l_q);
					p2_q       <= p1_q;
					p1_q       <= cur_q;
					l_q        <= l_q + 1'b1;
					if (l_q == '0) begin
						cur_q <= x_q;
					end
				end
			end
			S_MXP, S_MU, S_D0: begin
			end
			default: begin
			end
		endcase
	end

	// A result held back by the output side stays unchanged.
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid &&
			$stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("held result changed before it was taken");

	// Every emitted value stays within [-1, 1].
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[37:6]) <= ONE_S &&
			$signed(m_axis_tdata[37:6]) >= MINUS_ONE))
		else $error("result value out of range");

	// Each run starts with P_0 = 1 at degree zero.
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_EMIT && cur_q == ONE_S && l_q == '0))
		else $error("run did not start with degree zero");

	// The partial-product sequence only runs in order.
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> ($past(state_q) == S_D4))
		else $error("division steps out of order");

endmodule
